// ----- hw/rtl/keyword_decimal_field_scanner_defines.svh -----
// Assertion macros for the keyword decimal field scanner.
`ifndef KEYWORD_DECIMAL_FIELD_SCANNER_DEFINES_SVH
`define KEYWORD_DECIMAL_FIELD_SCANNER_DEFINES_SVH

`ifndef SYNTHESIS
`define KDFS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define KDFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KDFS_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define KDFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/kdfs_pkg.sv -----
// Shared types, constants and the keyword match function of the scanner.
package kdfs_pkg;

  localparam int unsigned KeyLen = 8;

  localparam logic [7:0] KEY_BYTES [KeyLen] = '{
    8'h73, 8'h65, 8'h63, 8'h74, 8'h6f, 8'h72, 8'h73, 8'h3d
  };

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_S    = 8'h73;
  localparam logic [7:0] CHAR_E    = 8'h65;

  typedef enum logic [2:0] {
    PH_SEARCH = 3'b001,
    PH_DIGITS = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } in_item_t;

  // Progress after one byte, 0..8. A mismatch leaves at most "s" matched, or
  // "se" when "sectors" was matched and the byte is 'e'.
  function automatic logic [3:0] next_progress(input logic [2:0] p, input logic [7:0] b);
    logic [3:0] np;
    if (b == KEY_BYTES[p]) begin
      np = {1'b0, p} + 4'd1;
    end else if ((p == 3'd7) && (b == CHAR_E)) begin
      np = 4'd2;
    end else if (b == CHAR_S) begin
      np = 4'd1;
    end else begin
      np = 4'd0;
    end
    return np;
  endfunction

endpackage

// ----- hw/rtl/kdfs_in_stage.sv -----
// Input register stage of the scanner.
module kdfs_in_stage import kdfs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data,
  input  logic       in_last,
  input  logic       advance,
  output in_item_t   item
);

  logic       valid;
  logic [7:0] data;
  logic       last;

  assign in_ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= in_data;
      last <= in_last;
    end
  end

  assign item = '{valid: valid, data: data, last: last};

endmodule

// ----- hw/rtl/kdfs_scan_core.sv -----
// Keyword match, digit accumulation and the result register.
module kdfs_scan_core import kdfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  in_item_t    item,
  output logic        advance,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [63:0] out_count
);

  phase_t      phase, phase_next;
  logic [2:0]  progress, progress_next;
  logic [63:0] acc, acc_next;
  logic [3:0]  np;
  logic        is_digit;
  logic        found;

  // A byte that closes a sector needs the result register free.
  assign advance = item.valid && (!item.last || !out_valid || out_ready);

  assign np       = next_progress(progress, item.data);
  assign is_digit = (item.data >= CHAR_ZERO) && (item.data <= CHAR_NINE);

  always_comb begin
    phase_next    = phase;
    progress_next = progress;
    acc_next      = acc;
    case (phase)
      PH_SEARCH: begin
        if (np[3]) begin
          phase_next    = PH_DIGITS;
          progress_next = 3'd0;
          acc_next      = 64'd0;
        end else begin
          progress_next = np[2:0];
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          acc_next = {acc[60:0], 3'b000} + {acc[62:0], 1'b0}
                   + {60'd0, item.data[3:0]};
        end else begin
          phase_next = PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  assign found = (phase_next != PH_SEARCH);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_SEARCH;
      progress <= 3'd0;
      acc      <= 64'd0;
    end else if (advance) begin
      if (item.last) begin
        phase    <= PH_SEARCH;
        progress <= 3'd0;
        acc      <= 64'd0;
      end else begin
        phase    <= phase_next;
        progress <= progress_next;
        acc      <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && item.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item.last) begin
      out_found <= found;
      out_count <= found ? acc_next : 64'd0;
    end
  end

endmodule

// ----- hw/rtl/keyword_decimal_field_scanner.sv -----
// Top level of the keyword decimal field scanner.
//
//   channel | dir | tdata                      | tuser             | tlast
//   s_*     | in  | [7:0] data_byte            | -                 | end_of_sector
//   m_*     | out | [63:0] parsed_count        | [0] keyword_found | -
//
// One byte is taken every cycle; the state update is a single pass between
// the input register and the result register, which is loaded as the last
// byte of a sector leaves the input register. Reset clears the match state and
// both valid flags. Only a last byte waiting behind an untaken result stalls
// the input; other bytes keep flowing while a result waits.
`include "keyword_decimal_field_scanner_defines.svh"

module keyword_decimal_field_scanner import kdfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] parsed_count
  output logic        m_tuser    // [0] keyword_found
);

  in_item_t in_q;
  logic     advance;

  kdfs_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_data  (s_tdata),
    .in_last  (s_tlast),
    .advance  (advance),
    .item     (in_q)
  );

  kdfs_scan_core u_scan_core (
    .clk       (clk),
    .rst       (rst),
    .item      (in_q),
    .advance   (advance),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_found (m_tuser),
    .out_count (m_tdata)
  );

  `KDFS_ASSERT_NOW(a_absent_count_zero, clk, rst, m_tvalid && !m_tuser, m_tdata == 64'd0,
    "count must be zero when the keyword is absent")
  `KDFS_ASSERT_NOW(a_stall_only_on_last, clk, rst, !s_tready,
    in_q.valid && in_q.last && m_tvalid && !m_tready,
    "input stalled without a blocked sector end")
  `KDFS_ASSERT_NOW(a_result_from_last, clk, rst, $rose(m_tvalid),
    $past(in_q.valid && in_q.last),
    "result raised without a sector end byte")

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the keyword decimal field scanner.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import kdfs_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned RANDOM_BYTES   = 850;

  // Progress kept after a mismatch at a given progress, indexed by progress.
  localparam logic [3:0] KEY_FALLBACK [KeyLen] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1
  };

  typedef struct packed {
    logic        found;
    logic [63:0] count;
  } scan_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;           // [63:0] parsed_count
  logic        m_tuser;           // [0] keyword_found

  scan_result_t pending_results [$];
  logic [7:0]   sector_bytes [$];
  int unsigned  mismatch_count = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  random_bytes_sent = 0;
  logic         tx_steady = 1'b0;
  logic         rx_steady = 1'b0;
  logic         hold_request = 1'b0;

  phase_t      pred_phase = PH_SEARCH;
  logic [2:0]  pred_progress = 3'd0;
  logic [63:0] pred_value = 64'd0;

  keyword_decimal_field_scanner i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [3:0] keyword_progress_after(input logic [2:0] progress,
                                                        input logic [7:0] b);
    logic [3:0] p;
    p = {1'b0, progress};
    for (int i = 0; i < KeyLen + 1; i++) begin
      if (KEY_BYTES[p[2:0]] == b) return p + 4'd1;
      if (p == 4'd0) return 4'd0;
      p = KEY_FALLBACK[p[2:0]];
    end
    return 4'd0;
  endfunction

  task automatic predict_scan_byte(input logic [7:0] b, input logic is_last);
    logic [3:0]   np;
    scan_result_t r;
    case (pred_phase)
      PH_SEARCH: begin
        np = keyword_progress_after(pred_progress, b);
        if (np == KeyLen) begin
          pred_phase    = PH_DIGITS;
          pred_progress = 3'd0;
          pred_value    = 64'd0;
        end else begin
          pred_progress = np[2:0];
        end
      end
      PH_DIGITS: begin
        if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
          pred_value = pred_value * 64'd10 + {56'd0, b - CHAR_ZERO};
        end else begin
          pred_phase = PH_DONE;
        end
      end
      default: ;
    endcase
    if (is_last) begin
      r.found = (pred_phase != PH_SEARCH);
      r.count = r.found ? pred_value : 64'd0;
      pending_results.push_back(r);
      pred_phase    = PH_SEARCH;
      pred_progress = 3'd0;
      pred_value    = 64'd0;
    end
  endtask

  // Leaves s_tvalid high on return; the next request lowers it only if it has a gap.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int unsigned gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= is_last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_scan_byte(b, is_last);
  endtask

  task automatic send_sector();
    for (int i = 0; i < sector_bytes.size(); i++) begin
      send_byte(sector_bytes[i], i == sector_bytes.size() - 1);
    end
    sector_bytes.delete();
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) sector_bytes.push_back(s[i]);
  endtask

  task automatic push_keyword(input int unsigned n);
    for (int i = 0; i < n; i++) sector_bytes.push_back(KEY_BYTES[i]);
  endtask

  task automatic push_digits(input int unsigned n);
    for (int i = 0; i < n; i++) sector_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // Noise leans toward keyword letters and digits to provoke partial matches.
  task automatic push_noise(input int unsigned n);
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r < 4) sector_bytes.push_back(8'($urandom_range(0, 255)));
      else if (r < 7) sector_bytes.push_back(KEY_BYTES[$urandom_range(0, KeyLen - 1)]);
      else sector_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  task automatic build_random_sector();
    int unsigned kind;
    int unsigned r;
    int unsigned keep;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      push_noise($urandom_range(0, 4));
      r = $urandom_range(0, 9);
      if (r == 0) push_keyword($urandom_range(1, 7));
      else if (r == 1) push_text("sectorsectors");
      push_keyword(KeyLen);
      r = $urandom_range(0, 19);
      if (r < 12) push_digits($urandom_range(0, 4));
      else if (r < 17) push_digits($urandom_range(5, 19));
      else push_digits($urandom_range(20, 25));
      push_noise($urandom_range(0, 4));
      if ($urandom_range(0, 3) == 0) push_keyword(KeyLen);
      if ($urandom_range(0, 3) == 0) begin
        keep = $urandom_range(1, sector_bytes.size());
        while (sector_bytes.size() > keep) void'(sector_bytes.pop_back());
      end
    end else if (kind < 85) begin
      push_noise($urandom_range(0, 3));
      if ($urandom_range(0, 1) == 0) begin
        push_keyword(KeyLen);
        sector_bytes[sector_bytes.size() - 1 - $urandom_range(0, KeyLen - 1)] =
          8'($urandom_range(0, 255));
      end else begin
        push_keyword($urandom_range(1, 7));
      end
      push_digits($urandom_range(0, 6));
      push_noise($urandom_range(1, 4));
    end else begin
      r = $urandom_range(1, 20);
      for (int i = 0; i < r; i++) sector_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_directed();
    push_text("sectors=");
    send_sector();
    sector_bytes.push_back(8'hff);
    send_sector();
    push_text("ssectors=9");
    send_sector();
    push_text("sectors=x");
    send_sector();
  endtask

  task automatic test_random_sectors();
    while (random_bytes_sent < RANDOM_BYTES) begin
      tx_steady = ($urandom_range(0, 9) == 0);
      build_random_sector();
      random_bytes_sent += sector_bytes.size();
      send_sector();
    end
    tx_steady = 1'b0;
  endtask

  // The receiver stops for a long stretch while bytes keep coming, so a
  // second last byte has to stall behind the untaken result.
  task automatic test_output_stall();
    tx_steady    = 1'b1;
    hold_request = 1'b1;
    for (int i = 0; i < 6; i++) begin
      push_noise($urandom_range(0, 2));
      push_keyword(KeyLen);
      push_digits($urandom_range(1, 3));
      send_sector();
    end
    tx_steady = 1'b0;
  endtask

  // Result side: random holds, steady stretches, and one long hold on request.
  initial begin
    int unsigned off_left;
    off_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        off_left     = HOLD_CYCLES;
      end
      if ($urandom_range(0, 199) == 0) rx_steady = ~rx_steady;
      if (off_left != 0) begin
        m_tready <= 1'b0;
        off_left--;
      end else if (rx_steady) begin
        m_tready <= 1'b1;
      end else begin
        off_left = pick_gap();
        m_tready <= (off_left == 0);
        if (off_left != 0) off_left--;
      end
    end
  end

  always @(posedge clk) begin
    scan_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("ERROR: unexpected result found=%0b count=%0d", m_tuser, m_tdata);
        end
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.found || m_tdata !== want.count) begin
          if (mismatch_count < 10) begin
            $display("ERROR: expected found=%0b count=%0d, got found=%0b count=%0d",
                     want.found, want.count, m_tuser, m_tdata);
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_sectors();
    test_output_stall();
    test_random_sectors();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
